// File: rtl/byte_rate_pacer_assert.svh
// ---------------------------------------------------------------------------
// byte_rate_pacer assertion macros
// Shared macros for the concurrent checks, clocked on clk, off during rst.
// ---------------------------------------------------------------------------
`ifndef BYTE_RATE_PACER_ASSERT_SVH
`define BYTE_RATE_PACER_ASSERT_SVH

// same-cycle implication
`define BRP_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/brp_pkg.sv
// ---------------------------------------------------------------------------
// brp_pkg
// Fixed field widths, constants and shared types of the byte rate pacer.
// ---------------------------------------------------------------------------
package brp_pkg;

  localparam int SIZE_W  = 32;  // container size
  localparam int RATE_W  = 32;  // rate register, also serial operand width
  localparam int COUNT_W = 20;  // payload count / index

  localparam logic [RATE_W-1:0] NS_PER_SEC = 32'd1000000000;

  // count / 10 == (count * QUANT_RECIP) >> QUANT_SHIFT, exact for 20-bit count
  localparam int                 QUANT_RECIP_W = 20;
  localparam logic [QUANT_RECIP_W-1:0] QUANT_RECIP = 20'd838861;
  localparam int                 QUANT_SHIFT   = 23;

  localparam int MUL_CNT_W = $clog2(RATE_W + 1);

  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, result valid
  } brp_unit_sts_t;

endpackage

// File: rtl/brp_channels.sv
// ---------------------------------------------------------------------------
// brp channels
// Valid/ready channel interfaces for pacer requests and pacing results.
// ---------------------------------------------------------------------------
interface brp_in_if
  import brp_pkg::*;
#(
  parameter int TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_time;
  logic [SIZE_W-1:0]    container_size;
  logic [COUNT_W-1:0]   payload_count;
  logic [COUNT_W-1:0]   payload_index;

  modport source (
    output valid, now_time, container_size, payload_count, payload_index,
    input  ready
  );
  modport sink (
    input  valid, now_time, container_size, payload_count, payload_index,
    output ready
  );
endinterface

interface brp_out_if
#(
  parameter int TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] sleep_time;
  logic                 checkpoint;

  modport source (
    output valid, sleep_time, checkpoint,
    input  ready
  );
  modport sink (
    input  valid, sleep_time, checkpoint,
    output ready
  );
endinterface

// File: rtl/brp_mul.sv
// ---------------------------------------------------------------------------
// brp_mul
// Serial shift-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module brp_mul
  import brp_pkg::*;
#(
  parameter int A_W = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [A_W-1:0]          a,
  input  logic [RATE_W-1:0]       b,
  output logic [A_W+RATE_W-1:0]   product,
  output brp_unit_sts_t           sts
);

  localparam int P_W = A_W + RATE_W;

  logic [P_W-1:0]       prod;
  logic [A_W-1:0]       mcand;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [A_W:0]         sum;

  // upper half plus multiplicand when the current low bit is set
  always_comb begin
    sum = {1'b0, prod[P_W-1:RATE_W]} + (prod[0] ? {1'b0, mcand} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= MUL_CNT_W'(RATE_W);
      end else if (busy) begin
        cnt <= cnt - MUL_CNT_W'(1);
        if (cnt == MUL_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= {{A_W{1'b0}}, b};
      mcand <= a;
    end else if (busy) begin
      prod <= {sum, prod[RATE_W-1:1]};
    end
  end

  assign product  = prod;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// File: rtl/brp_div.sv
// ---------------------------------------------------------------------------
// brp_div
// Serial restoring divider, one quotient bit per cycle.
// Expects the numerator bits above Q_W to be below the divisor.
// ---------------------------------------------------------------------------
module brp_div
  import brp_pkg::*;
#(
  parameter int Q_W = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [Q_W+RATE_W-1:0] numer,
  input  logic [RATE_W-1:0]     divisor,
  output logic [Q_W-1:0]        quotient,
  output logic [RATE_W-1:0]     remainder,
  output brp_unit_sts_t         sts
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [RATE_W-1:0] rem;
  logic [Q_W-1:0]    quo;    // numerator bits shift out, quotient bits in
  logic [RATE_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              fits;

  always_comb begin
    trial = {rem, quo[Q_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= numer[Q_W+RATE_W-1:Q_W];
      quo <= numer[Q_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      quo <= {quo[Q_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign sts.busy  = busy;
  assign sts.done  = done;

endmodule

// File: rtl/byte_rate_pacer.sv
// ---------------------------------------------------------------------------
// byte_rate_pacer
// Paces payloads of a container toward a target byte rate.
// ---------------------------------------------------------------------------
// One request in, one result out, one request at a time. A request with
// payload_index 0 opens a container: the time budget size*1e9/rate is built
// by the serial multiplier and the serial divider, then trimmed by the gap
// since the previous container ended when that gap is smaller; the divider
// is skipped when the budget saturates. Any other index first runs index
// mod quantum through the divider; a non-checkpoint then returns its result.
// A checkpoint with a nonzero count then forms index*budget/count with the
// multiplier and the divider again, the divider skipped when the share
// saturates. ready is high only while no request is in work; a finished
// result sits in the output register until taken, and the next request is
// taken meanwhile.
// ---------------------------------------------------------------------------
`include "byte_rate_pacer_assert.svh"

module byte_rate_pacer
  import brp_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_data,
  brp_in_if.sink            in_ch,
  brp_out_if.source         out_ch
);

  localparam int NW   = TIME_BITS + RATE_W;       // serial product width
  localparam int QP_W = COUNT_W + QUANT_RECIP_W;  // quantum product width

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL_B = 4'd1;  // size * 1e9
  localparam logic [3:0] ST_DIV_B = 4'd2;  // / rate
  localparam logic [3:0] ST_BUD   = 4'd3;  // trim budget, open container
  localparam logic [3:0] ST_MOD   = 4'd4;  // index mod quantum
  localparam logic [3:0] ST_MUL_S = 4'd5;  // index * budget
  localparam logic [3:0] ST_DIV_S = 4'd6;  // / count
  localparam logic [3:0] ST_CMP   = 4'd7;  // target vs elapsed
  localparam logic [3:0] ST_FIN   = 4'd8;  // record container end
  localparam logic [3:0] ST_OUT   = 4'd9;  // hand result to output register

  logic [3:0] state;
  logic [3:0] state_next;

  // configuration and pacing state
  logic [RATE_W-1:0]    rate_bps;
  logic [TIME_BITS-1:0] time_budget;
  logic [COUNT_W-1:0]   payload_quantum;
  logic [TIME_BITS-1:0] container_start;
  logic [TIME_BITS-1:0] container_end;

  // per-request working registers
  logic [TIME_BITS-1:0] now_r;
  logic [COUNT_W-1:0]   count_r;
  logic [COUNT_W-1:0]   idx_r;
  logic                 last_r;
  logic [TIME_BITS-1:0] over_r;     // now - previous container end
  logic [TIME_BITS-1:0] elapsed_r;  // now - container start
  logic [QP_W-1:0]      qprod;
  logic [TIME_BITS-1:0] bud_raw;
  logic [TIME_BITS-1:0] target;
  logic [TIME_BITS-1:0] res_sleep;
  logic                 res_ckpt;

  // output register
  logic                 out_valid;
  logic [TIME_BITS-1:0] out_sleep;
  logic                 out_ckpt;

  // serial units
  logic                 mul_start;
  logic [TIME_BITS-1:0] mul_a;
  logic [RATE_W-1:0]    mul_b;
  logic [NW-1:0]        mul_product;
  brp_unit_sts_t        mul_sts;
  logic                 div_start;
  logic [NW-1:0]        div_numer;
  logic [RATE_W-1:0]    div_divisor;
  logic [TIME_BITS-1:0] div_quotient;
  logic [RATE_W-1:0]    div_remainder;
  brp_unit_sts_t        div_sts;

  logic                 in_fire;
  logic [RATE_W-1:0]    prod_hi;
  logic                 bud_sat;
  logic                 share_sat;
  logic                 mod_ckpt;
  logic                 out_load;
  logic [COUNT_W-1:0]   quant_div;
  logic [COUNT_W-1:0]   quant_new;

  brp_mul #(.A_W(TIME_BITS)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_product),
    .sts     (mul_sts)
  );

  brp_div #(.Q_W(TIME_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numer     (div_numer),
    .divisor   (div_divisor),
    .quotient  (div_quotient),
    .remainder (div_remainder),
    .sts       (div_sts)
  );

  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state == ST_OUT) && (!out_valid || out_ch.ready);

  // Quotient overflows TIME_BITS exactly when the product's high part
  // reaches the divisor; that case saturates without running the divider.
  assign prod_hi   = mul_product[NW-1:TIME_BITS];
  assign bud_sat   = (rate_bps == '0) || (prod_hi >= rate_bps);
  assign share_sat = (prod_hi >= RATE_W'(count_r));
  assign mod_ckpt  = (div_remainder == '0) || last_r;

  // quantum = max(1, count / 10)
  assign quant_div = COUNT_W'(qprod[QP_W-1:QUANT_SHIFT]);
  assign quant_new = (quant_div == '0) ? COUNT_W'(1) : quant_div;

  always_comb begin
    state_next  = state;
    mul_start   = 1'b0;
    mul_a       = time_budget;
    mul_b       = RATE_W'(idx_r);
    div_start   = 1'b0;
    div_numer   = mul_product;
    div_divisor = rate_bps;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.payload_index == '0) begin
            mul_start  = 1'b1;
            mul_a      = TIME_BITS'(NS_PER_SEC);
            mul_b      = in_ch.container_size;
            state_next = ST_MUL_B;
          end else begin
            // quantum is never zero, so the divider precondition holds
            div_start   = 1'b1;
            div_numer   = NW'(in_ch.payload_index);
            div_divisor = RATE_W'(payload_quantum);
            state_next  = ST_MOD;
          end
        end
      end
      ST_MUL_B: begin
        if (mul_sts.done) begin
          if (bud_sat) begin
            state_next = ST_BUD;
          end else begin
            div_start  = 1'b1;
            state_next = ST_DIV_B;
          end
        end
      end
      ST_DIV_B: begin
        if (div_sts.done) begin
          state_next = ST_BUD;
        end
      end
      ST_BUD: begin
        state_next = ST_OUT;
      end
      ST_MOD: begin
        if (div_sts.done) begin
          if (!mod_ckpt || count_r == '0) begin
            state_next = ST_OUT;
          end else begin
            mul_start  = 1'b1;
            state_next = ST_MUL_S;
          end
        end
      end
      ST_MUL_S: begin
        if (mul_sts.done) begin
          if (share_sat) begin
            state_next = ST_CMP;
          end else begin
            div_start   = 1'b1;
            div_divisor = RATE_W'(count_r);
            state_next  = ST_DIV_S;
          end
        end
      end
      ST_DIV_S: begin
        if (div_sts.done) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control and pacing state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      rate_bps        <= RATE_W'(1);
      time_budget     <= '0;
      payload_quantum <= COUNT_W'(1);
      container_start <= '0;
      container_end   <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        rate_bps <= cfg_data;
      end
      if (state == ST_BUD) begin
        // overhead since the last container comes off only if smaller
        time_budget     <= (over_r < bud_raw) ? (bud_raw - over_r) : bud_raw;
        payload_quantum <= quant_new;
        container_start <= now_r;
      end
      if (state == ST_FIN && last_r) begin
        container_end <= now_r + res_sleep;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_r     <= in_ch.now_time;
      count_r   <= in_ch.payload_count;
      idx_r     <= in_ch.payload_index;
      last_r    <= (in_ch.payload_count != '0) &&
                   (in_ch.payload_index == in_ch.payload_count - COUNT_W'(1));
      over_r    <= in_ch.now_time - container_end;
      elapsed_r <= in_ch.now_time - container_start;
      qprod     <= QP_W'(in_ch.payload_count) * QP_W'(QUANT_RECIP);
      res_sleep <= '0;
      res_ckpt  <= 1'b0;
    end
    if (state == ST_MUL_B && mul_sts.done && bud_sat) begin
      bud_raw <= TIME_MAX;
    end
    if (state == ST_DIV_B && div_sts.done) begin
      bud_raw <= div_quotient;
    end
    if (state == ST_MOD && div_sts.done) begin
      res_ckpt <= mod_ckpt;
    end
    if (state == ST_MUL_S && mul_sts.done && share_sat) begin
      target <= TIME_MAX;
    end
    if (state == ST_DIV_S && div_sts.done) begin
      target <= div_quotient;
    end
    if (state == ST_CMP) begin
      res_sleep <= (target > elapsed_r) ? (target - elapsed_r) : '0;
    end
    if (out_load) begin
      out_sleep <= res_sleep;
      out_ckpt  <= res_ckpt;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sleep_time = out_sleep;
  assign out_ch.checkpoint = out_ckpt;

  // checks
  `BRP_ASSERT_HOLDS(a_quantum_nonzero, 1'b1, payload_quantum != '0, "quantum is zero")
  `BRP_ASSERT_HOLDS(a_mul_start_free, mul_start, !mul_sts.busy && !div_sts.busy, "mul start while busy")
  `BRP_ASSERT_HOLDS(a_div_start_free, div_start, !mul_sts.busy && !div_sts.busy, "div start while busy")
  `BRP_ASSERT_HOLDS(a_plain_zero_sleep, out_valid && !out_ckpt, out_sleep == '0, "sleep on plain payload")
  `BRP_ASSERT_NEXT(a_accept_busy, in_fire, state != ST_IDLE, "idle after transfer")

endmodule

// File: test/pace_sleep_check.sv
// ---------------------------------------------------------------------------
// pace_sleep_check
// Watches the pacer channels and the rate register writes, predicts the
// sleep time and checkpoint flag of every request and compares each result.
// ---------------------------------------------------------------------------
module pace_sleep_check
  import brp_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_data,
  brp_in_if                 in_mon,
  brp_out_if                out_mon,
  output int                errors,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TIME_BITS-1:0] TIME_MAX    = '1;
  localparam int                   QUANTUM_DIV = 10;

  typedef struct packed {
    logic [TIME_BITS-1:0] sleep;
    logic                 ckpt;
  } pace_result_t;

  // pacer state as the block should hold it
  logic [RATE_W-1:0]    byte_rate;
  logic [TIME_BITS-1:0] budget_ns;
  logic [COUNT_W-1:0]   quantum;
  logic [TIME_BITS-1:0] start_ns;
  logic [TIME_BITS-1:0] end_ns;

  pace_result_t sleep_q[$];
  pace_result_t want;
  int           mismatches = 0;
  int           backlog    = 0;

  assign errors      = mismatches;
  assign outstanding = backlog;

  function automatic pace_result_t pace_payload(input logic [TIME_BITS-1:0] now,
                                                input logic [SIZE_W-1:0]    size,
                                                input logic [COUNT_W-1:0]   count,
                                                input logic [COUNT_W-1:0]   idx);
    logic [127:0]         wide;
    logic [TIME_BITS-1:0] bud;
    logic [TIME_BITS-1:0] over;
    logic [TIME_BITS-1:0] target;
    logic [TIME_BITS-1:0] elapsed;
    logic                 last;
    pace_result_t         r;
    r.sleep = '0;
    r.ckpt  = 1'b0;
    if (idx == 0) begin
      // container open: budget, overhead trim, quantum, start time
      if (byte_rate == 0) begin
        bud = TIME_MAX;
      end else begin
        wide = (128'(size) * 128'(NS_PER_SEC)) / 128'(byte_rate);
        bud  = (wide > 128'(TIME_MAX)) ? TIME_MAX : wide[TIME_BITS-1:0];
      end
      over = now - end_ns;
      if (over < bud) bud = bud - over;
      budget_ns = bud;
      quantum   = (count < COUNT_W'(QUANTUM_DIV)) ? COUNT_W'(1) :
                  COUNT_W'(count / COUNT_W'(QUANTUM_DIV));
      start_ns  = now;
    end else begin
      last = (count != 0) && (idx == count - COUNT_W'(1));
      if ((idx % quantum) == 0 || last) begin
        r.ckpt = 1'b1;
        if (count != 0) begin
          wide    = (128'(idx) * 128'(budget_ns)) / 128'(count);
          target  = (wide > 128'(TIME_MAX)) ? TIME_MAX : wide[TIME_BITS-1:0];
          elapsed = now - start_ns;
          if (target > elapsed) r.sleep = target - elapsed;
        end
        if (last) end_ns = now + r.sleep;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      byte_rate = RATE_W'(1);
      budget_ns = '0;
      quantum   = COUNT_W'(1);
      start_ns  = '0;
      end_ns    = '0;
      sleep_q.delete();
      backlog  <= 0;
    end else begin
      if (cfg_we) byte_rate = cfg_data;
      if (out_mon.valid && out_mon.ready) begin
        if (sleep_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got sleep %0d checkpoint %0b",
                   $time, out_mon.sleep_time, out_mon.checkpoint);
          mismatches++;
        end else begin
          want = sleep_q.pop_front();
          if (want.sleep !== out_mon.sleep_time) begin
            $display("%0t: sleep_time mismatch, expected %0d, got %0d",
                     $time, want.sleep, out_mon.sleep_time);
            mismatches++;
          end
          if (want.ckpt !== out_mon.checkpoint) begin
            $display("%0t: checkpoint mismatch, expected %0b, got %0b",
                     $time, want.ckpt, out_mon.checkpoint);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        sleep_q.push_back(pace_payload(in_mon.now_time, in_mon.container_size,
                                       in_mon.payload_count, in_mon.payload_index));
      backlog <= sleep_q.size();
    end
  end

endmodule

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives payload requests and rate register writes into byte_rate_pacer,
// randomizes idling on both channels and reports the verdict of the checker.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brp_pkg::*;

  localparam int TIME_BITS     = 48;
  localparam int LONG_HOLD     = 500;   // receiver hold-off, cycles
  localparam int DRAIN_LIMIT   = 20000; // cap on the final wait
  localparam int SETTLE_CYCLES = 300;   // longer than the slowest request
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 195;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [RATE_W-1:0] cfg_data = '0;

  brp_in_if  #(.TIME_BITS(TIME_BITS)) in_ch ();
  brp_out_if #(.TIME_BITS(TIME_BITS)) out_ch ();

  int errors;
  int outstanding;

  // idle odds in percent, and hold-off requests for the receiver
  int tx_idle_pct = 12;
  int rx_idle_pct = 54;
  int stall_reqs  = 0;

  // running notion of "now" for well-formed containers
  logic [TIME_BITS-1:0] clock_ns = '0;

  byte_rate_pacer #(.TIME_BITS(TIME_BITS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  pace_sleep_check #(.TIME_BITS(TIME_BITS)) sleep_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  // hard stop, far beyond the slowest legal run (~2000 items)
  initial begin
    #60ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Receiver: random ready, plus a long hold-off whenever the stimulus
  // asks for one. The hold is counted here so the sender keeps offering
  // requests and the block fills (one in work, one parked in the output).
  initial begin
    int hold_left;
    int stalls_done;
    hold_left   = 0;
    stalls_done = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_reqs != stalls_done) begin
        stalls_done++;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [TIME_BITS-1:0] rand_ns();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  // One transfer on the request channel. valid is left high on return so a
  // back-to-back request needs no second assignment in the same step; the
  // next caller either refreshes the payload or drops valid.
  task automatic send_payload(input logic [TIME_BITS-1:0] t,
                              input logic [SIZE_W-1:0]    sz,
                              input logic [COUNT_W-1:0]   cnt,
                              input logic [COUNT_W-1:0]   ix);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.now_time       <= t;
    in_ch.container_size <= sz;
    in_ch.payload_count  <= cnt;
    in_ch.payload_index  <= ix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Rate writes only with the block idle: drop valid, wait until every
  // predicted result has been taken, then pulse the write enable.
  task automatic set_rate(input logic [RATE_W-1:0] rate);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= rate;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Random traffic: mostly whole containers (index 0 .. count-1 with time
  // moving forward), some sparse walks through huge containers that hit
  // quantum checkpoints and the last payload, and some raw noise.
  task automatic pace_containers(input int quota);
    int                 sent;
    int                 pick;
    int                 hops;
    int                 shift;
    logic [SIZE_W-1:0]  sz;
    logic [COUNT_W-1:0] cnt;
    logic [COUNT_W-1:0] q;
    logic [COUNT_W-1:0] ix;
    sent = 0;
    while (sent < quota) begin
      pick  = $urandom_range(99);
      sz    = $urandom >> $urandom_range(31);
      shift = $urandom_range(30);
      // occasional jump, also backwards or close to the wrap
      if ($urandom_range(19) == 0) clock_ns = rand_ns();
      clock_ns += TIME_BITS'($urandom_range(1 << shift));
      if (pick < 65) begin
        cnt = COUNT_W'($urandom_range(30, 1));
        for (int i = 0; i < int'(cnt); i++) begin
          send_payload(clock_ns, sz, cnt, COUNT_W'(i));
          clock_ns += TIME_BITS'($urandom_range(1 << shift));
        end
        sent += int'(cnt);
      end else if (pick < 82) begin
        cnt = COUNT_W'(31 + ($urandom_range(20'hFFFFF - 31) >> $urandom_range(19)));
        q   = cnt / COUNT_W'(10);
        send_payload(clock_ns, sz, cnt, '0);
        hops = $urandom_range(8, 2);
        for (int h = 0; h < hops; h++) begin
          clock_ns += TIME_BITS'($urandom_range(1 << shift));
          if ($urandom_range(1) == 0)
            ix = COUNT_W'(int'(q) * $urandom_range(9, 1));
          else
            ix = COUNT_W'($urandom_range(int'(cnt) - 1, 1));
          send_payload(clock_ns, sz, cnt, ix);
        end
        clock_ns += TIME_BITS'($urandom_range(1 << shift));
        send_payload(clock_ns, sz, cnt, cnt - COUNT_W'(1));
        sent += hops + 2;
      end else begin
        // noise: any field, zero counts, indexes past the count
        cnt = ($urandom_range(3) == 0) ? '0 : COUNT_W'($urandom);
        send_payload(rand_ns(), $urandom, cnt, COUNT_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [RATE_W-1:0] rate_plan [PHASES];
    int                drained;
    in_ch.valid          = 1'b0;
    in_ch.now_time       = '0;
    in_ch.container_size = '0;
    in_ch.payload_count  = '0;
    in_ch.payload_index  = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // zero rate: budget saturates, small container
    set_rate('0);
    send_payload(48'd1000, 32'd5, 20'd3, 20'd0);
    send_payload(48'd2000, 32'd5, 20'd3, 20'd1);
    send_payload(48'd3000, 32'd5, 20'd3, 20'd2);

    // rate 1: saturated budget, widest fields, end wraps past the time range
    set_rate(RATE_W'(1));
    send_payload(48'hFFFF_FFFF_F000, '1, '1, 20'd0);
    send_payload(48'hFFFF_FFFF_F100, '1, '1, 20'd314571);   // quantum multiple
    send_payload(48'hFFFF_FFFF_F200, '1, '1, 20'hFFFFE);    // last payload
    send_payload(48'h0000_0000_0010, '1, '1, 20'd5);        // no checkpoint

    set_rate(RATE_W'(1_000_000));
    send_payload(48'd100, 32'd0, 20'd1, 20'd0);      // count 1 opens only
    send_payload(48'd200, 32'd1000, 20'd0, 20'd0);   // zero count
    send_payload(48'd300, 32'd1000, 20'd0, 20'd7);   // checkpoint, sleep 0
    send_payload(48'd400, 32'd1000, 20'd4, 20'd0);
    send_payload(48'd500, 32'd1000, 20'd4, 20'd9);   // index past the count
    send_payload(48'd600, 32'd1000, 20'd4, 20'd3);
    send_payload(48'd700, 32'd1000, 20'd25, 20'd0);  // quantum 2
    send_payload(48'd800, 32'd1000, 20'd25, 20'd1);
    send_payload(48'd900, 32'd1000, 20'd25, 20'd2);
    send_payload(48'd5000000, 32'd1000, 20'd25, 20'd24);  // late: sleep 0
    send_payload(48'd1000, 32'd1, 20'd20, 20'd0);    // now before last end
    send_payload(48'd10, 32'd1, 20'd20, 20'd19);     // now before start

    // ---- random part, one rate per phase ----
    rate_plan = '{32'hFFFF_FFFF, 32'd125_000_000, 32'd1000, 32'd1_000_000,
                  32'd1, $urandom, 32'd0, 32'd10_000_000, $urandom};
    for (int p = 0; p < PHASES; p++) begin
      set_rate(rate_plan[p]);
      case (p / 3)
        0: begin
          tx_idle_pct = 12;
          rx_idle_pct = 54;
        end
        1: begin
          tx_idle_pct = 54;
          rx_idle_pct = 12;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      // long receiver hold-offs while the sender keeps pushing
      if (p == 6 || p == 7) stall_reqs++;
      pace_containers(PHASE_ITEMS);
    end

    // ---- drain and verdict ----
    in_ch.valid <= 1'b0;
    @(posedge clk);
    drained = 0;
    while (outstanding != 0 && drained < DRAIN_LIMIT) begin
      @(posedge clk);
      drained++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (outstanding != 0)
      $display("%0t: %0d expected results never arrived", $time, outstanding);
    if (errors == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/brp_pkg.sv
rtl/brp_channels.sv
rtl/brp_mul.sv
rtl/brp_div.sv
rtl/byte_rate_pacer.sv
test/pace_sleep_check.sv
test/testbench.sv
